@@ hdl/bpfp_pkg.sv @@
// Types, codes and helpers shared by the batch proof frame parser and its checker.
package bpfp_pkg;

  typedef enum logic [12:0] {
    PH_ID     = 13'b0000000000001,
    PH_PREV   = 13'b0000000000010,
    PH_NEW    = 13'b0000000000100,
    PH_COUNT  = 13'b0000000001000,
    PH_PSIZE  = 13'b0000000010000,
    PH_PROOF  = 13'b0000000100000,
    PH_COMMIT = 13'b0000001000000,
    PH_NULL   = 13'b0000010000000,
    PH_VALUE  = 13'b0000100000000,
    PH_TYPE   = 13'b0001000000000,
    PH_DEST   = 13'b0010000000000,
    PH_SIG    = 13'b0100000000000,
    PH_IDLE   = 13'b1000000000000
  } phase_e;

  typedef enum logic [2:0] {
    ERR_NONE   = 3'd0,
    ERR_TRUNC  = 3'd1,
    ERR_ZPROOF = 3'd2,
    ERR_COUNT  = 3'd3,
    ERR_TYPE   = 3'd4,
    ERR_TRAIL  = 3'd5
  } err_e;

  localparam logic [3:0] FC_ID      = 4'd0;
  localparam logic [3:0] FC_PREV    = 4'd1;
  localparam logic [3:0] FC_NEW     = 4'd2;
  localparam logic [3:0] FC_COUNT   = 4'd3;
  localparam logic [3:0] FC_PSIZE   = 4'd4;
  localparam logic [3:0] FC_PROOF   = 4'd5;
  localparam logic [3:0] FC_COMMIT  = 4'd6;
  localparam logic [3:0] FC_NULL    = 4'd7;
  localparam logic [3:0] FC_VALUE   = 4'd8;
  localparam logic [3:0] FC_TYPE    = 4'd9;
  localparam logic [3:0] FC_DEST    = 4'd10;
  localparam logic [3:0] FC_SIG     = 4'd11;
  localparam logic [3:0] FC_IGNORED = 4'd12;

  localparam logic [15:0] MAX_COUNT_RST = 16'd256;

  function automatic logic [3:0] field_code_f(phase_e ph);
    logic [3:0] code;
    case (ph)
      PH_ID:     code = FC_ID;
      PH_PREV:   code = FC_PREV;
      PH_NEW:    code = FC_NEW;
      PH_COUNT:  code = FC_COUNT;
      PH_PSIZE:  code = FC_PSIZE;
      PH_PROOF:  code = FC_PROOF;
      PH_COMMIT: code = FC_COMMIT;
      PH_NULL:   code = FC_NULL;
      PH_VALUE:  code = FC_VALUE;
      PH_TYPE:   code = FC_TYPE;
      PH_DEST:   code = FC_DEST;
      PH_SIG:    code = FC_SIG;
      default:   code = FC_IGNORED;
    endcase
    return code;
  endfunction

endpackage

@@ hdl/batch_proof_frame_parser.sv @@
// Batch proof frame parser: byte-stream field tagger and frame checker.
// One byte per beat in, one tagged result beat out per byte, in the cycle after acceptance; a new
// byte is taken every clock as long as the output register is empty or being drained, so the
// sustained rate is one byte per cycle, set by the single parse-state register update.
// Each result carries the byte, its field code (tuser), offset within the field and entry
// number; the beat for the final input byte has tlast set and carries frame_ok / error_code
// (1 truncated, 2 zero proof size, 3 count above max_entry_count, 4 type byte above 1,
// 5 trailing bytes). Parse state returns to the frame start after every final byte.
module batch_proof_frame_parser import bpfp_pkg::*; #(
  parameter int SIGNATURE_BYTES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,    // max_entry_count
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tlast,   // last_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [7:0] out_byte, [39:8] field_offset,
                                      // [55:40] entry_number, [56] frame_ok,
                                      // [59:57] error_code, [63:60] zero
  output logic [3:0]  m_axis_tuser,   // field_code
  output logic        m_axis_tlast    // frame_done
);

  localparam logic [31:0] SigLen = 32'(SIGNATURE_BYTES);

  logic [15:0] max_cnt_q;
  phase_e      phase_q, phase_d;
  logic [31:0] fcnt_q, fcnt_d;
  logic [15:0] eidx_q, eidx_d;
  logic [31:0] etot_q, etot_d;
  logic [31:0] plen_q, plen_d;
  logic [31:0] gath_q, gath_d;
  err_e        ferr_q, ferr_d;

  logic        ovld_q;
  logic [63:0] odata_q, odata_d;
  logic [3:0]  ouser_q, ouser_d;
  logic        olast_q;

  logic        accept;
  logic [7:0]  b;
  logic [31:0] fcnt_inc;
  logic [31:0] flen;
  logic [31:0] gath_nxt;
  logic [15:0] eidx_inc;
  logic [3:0]  code;
  logic [31:0] off;
  logic [15:0] ent;
  logic        ok;
  err_e        rep_err;

  assign s_axis_tready = !ovld_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign b             = s_axis_tdata;
  assign fcnt_inc      = fcnt_q + 32'd1;
  assign eidx_inc      = eidx_q + 16'd1;

  always_comb begin
    case (phase_q)
      PH_ID, PH_COUNT, PH_PSIZE:            flen = 32'd4;
      PH_PREV, PH_NEW, PH_COMMIT, PH_NULL:  flen = 32'd32;
      PH_PROOF:                             flen = plen_q;
      PH_VALUE:                             flen = 32'd8;
      PH_TYPE:                              flen = 32'd1;
      PH_DEST:                              flen = 32'd20;
      default:                              flen = SigLen;
    endcase
  end

  always_comb begin
    case (fcnt_q[1:0])
      2'd0:    gath_nxt = gath_q | {24'd0, b};
      2'd1:    gath_nxt = gath_q | {16'd0, b, 8'd0};
      2'd2:    gath_nxt = gath_q | {8'd0, b, 16'd0};
      default: gath_nxt = gath_q | {b, 24'd0};
    endcase
  end

  always_comb begin
    phase_d = phase_q;
    fcnt_d  = fcnt_q;
    eidx_d  = eidx_q;
    etot_d  = etot_q;
    plen_d  = plen_q;
    gath_d  = gath_q;
    ferr_d  = ferr_q;
    code    = FC_IGNORED;
    off     = 32'd0;
    ent     = 16'd0;
    ok      = 1'b0;
    rep_err = ERR_NONE;

    if (phase_q == PH_IDLE) begin
      if (ferr_q == ERR_NONE) begin
        ferr_d = ERR_TRAIL;
      end
    end else begin
      code   = field_code_f(phase_q);
      off    = fcnt_q;
      if (phase_q == PH_COMMIT || phase_q == PH_NULL || phase_q == PH_VALUE ||
          phase_q == PH_TYPE || phase_q == PH_DEST) begin
        ent = eidx_q;
      end
      if (phase_q == PH_COUNT || phase_q == PH_PSIZE) begin
        gath_d = gath_nxt;
      end
      if (phase_q == PH_TYPE && b > 8'd1) begin
        ferr_d = ERR_TYPE;
      end
      fcnt_d = fcnt_inc;
      if (ferr_d != ERR_NONE) begin
        phase_d = PH_IDLE;
        fcnt_d  = 32'd0;
      end else if (fcnt_inc >= flen) begin
        fcnt_d = 32'd0;
        case (phase_q)
          PH_ID:     phase_d = PH_PREV;
          PH_PREV:   phase_d = PH_NEW;
          PH_NEW:    phase_d = PH_COUNT;
          PH_COUNT: begin
            etot_d  = gath_nxt;
            gath_d  = 32'd0;
            phase_d = PH_PSIZE;
          end
          PH_PSIZE: begin
            plen_d = gath_nxt;
            gath_d = 32'd0;
            if (gath_nxt == 32'd0) begin
              ferr_d  = ERR_ZPROOF;
              phase_d = PH_IDLE;
            end else if (etot_q > {16'd0, max_cnt_q}) begin
              ferr_d  = ERR_COUNT;
              phase_d = PH_IDLE;
            end else begin
              phase_d = PH_PROOF;
            end
          end
          PH_PROOF: begin
            eidx_d  = 16'd0;
            phase_d = (etot_q == 32'd0) ? PH_SIG : PH_COMMIT;
          end
          PH_COMMIT: phase_d = PH_NULL;
          PH_NULL:   phase_d = PH_VALUE;
          PH_VALUE:  phase_d = PH_TYPE;
          PH_TYPE:   phase_d = PH_DEST;
          PH_DEST: begin
            eidx_d  = eidx_inc;
            phase_d = ({16'd0, eidx_inc} >= etot_q) ? PH_SIG : PH_COMMIT;
          end
          default:   phase_d = PH_IDLE;
        endcase
      end
    end

    if (s_axis_tlast) begin
      rep_err = ferr_d;
      if (phase_d != PH_IDLE && ferr_d == ERR_NONE) begin
        rep_err = ERR_TRUNC;
      end
      ok      = (rep_err == ERR_NONE);
      phase_d = PH_ID;
      fcnt_d  = 32'd0;
      eidx_d  = 16'd0;
      etot_d  = 32'd0;
      plen_d  = 32'd0;
      gath_d  = 32'd0;
      ferr_d  = ERR_NONE;
    end

    odata_d = {4'd0, rep_err, ok, ent, off, b};
    ouser_d = code;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_cnt_q <= MAX_COUNT_RST;
    end else if (cfg_we_i) begin
      max_cnt_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_ID;
      fcnt_q  <= 32'd0;
      eidx_q  <= 16'd0;
      etot_q  <= 32'd0;
      plen_q  <= 32'd0;
      gath_q  <= 32'd0;
      ferr_q  <= ERR_NONE;
    end else if (accept) begin
      phase_q <= phase_d;
      fcnt_q  <= fcnt_d;
      eidx_q  <= eidx_d;
      etot_q  <= etot_d;
      plen_q  <= plen_d;
      gath_q  <= gath_d;
      ferr_q  <= ferr_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovld_q  <= 1'b0;
      olast_q <= 1'b0;
    end else if (s_axis_tready) begin
      ovld_q  <= s_axis_tvalid;
      olast_q <= s_axis_tlast;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      odata_q <= odata_d;
      ouser_q <= ouser_d;
    end
  end

  assign m_axis_tvalid = ovld_q;
  assign m_axis_tdata  = odata_q;
  assign m_axis_tuser  = ouser_q;
  assign m_axis_tlast  = olast_q;

endmodule

@@ hdl/bpfp_checker.sv @@
// Port-level checker for the batch proof frame parser, with its bind.
module bpfp_checker import bpfp_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic [3:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result beat dropped while stalled");

  a_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
    else $error("accepted byte did not produce a result beat");

  a_status_only_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[59:57] == ERR_NONE && !m_axis_tdata[56])
    else $error("frame status outside final beat");

  a_ok_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[56] |-> m_axis_tdata[59:57] == ERR_NONE)
    else $error("frame_ok with an error code");

  a_ignored_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == FC_IGNORED |->
      m_axis_tdata[39:8] == 32'd0 && m_axis_tdata[55:40] == 16'd0)
    else $error("ignored byte with nonzero offset or entry");

endmodule

bind batch_proof_frame_parser bpfp_checker u_bpfp_checker (.*);

@@ tb/sv/batch_proof_frame_parser_tb.sv @@
// Self-checking testbench: batch frames in, tagged beats compared against a local field tracker.
`timescale 1ns / 100ps

module batch_proof_frame_parser_tb;
  import bpfp_pkg::*;

  localparam int SIG_BYTES  = 64;
  localparam int RAND_BYTES = 200;
  localparam int HOLD_CYCLES = 300;
  localparam int WATCHDOG   = 2000;

  typedef struct {
    logic [7:0]  data;
    logic [3:0]  code;
    logic [31:0] offset;
    logic [15:0] entry;
    logic        done;
    logic        ok;
    logic [2:0]  err;
  } tag_t;

  typedef struct {
    int          cfg;        // -1: no register write before the frame
    logic [31:0] count_val;
    logic [31:0] proof_val;
    int          n_ent;
    int          bad_ent;    // -1: every type byte legal
    int          bad_val;
    int          fill;       // -1: random payload bytes
    int          trunc_len;  // 0: full frame
    int          extra;
    int          want_err;   // -1: status left to the tracker
  } frame_spec_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;
  logic [3:0]  m_axis_tuser;
  logic        m_axis_tlast;

  batch_proof_frame_parser #(
    .SIGNATURE_BYTES(SIG_BYTES)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always #1 clk_i = ~clk_i;

  // field tracker state
  logic [3:0]  stage;
  logic [31:0] pos;
  logic [15:0] entry_idx;
  logic [31:0] entries_hdr;
  logic [31:0] proof_len;
  logic [31:0] gather;
  err_e        first_err;
  logic [15:0] max_entries;

  tag_t       want_tags[$];
  int         want_status[$];
  logic [7:0] frame_bytes[$];

  int fails = 0;
  int sent_bytes = 0;
  int idle_cycles = 0;
  bit tx_calm = 1'b1;
  bit rx_calm = 1'b1;
  bit hold_req = 1'b0;

  frame_spec_t plan [13] = '{
    '{-1, 0,            1,            0,   -1, 0,   -1,   1,   0, int'(ERR_TRUNC)},
    '{-1, 2,            1,            2,   -1, 0,   255,  0,   0, int'(ERR_NONE)},
    '{-1, 1,            0,            0,   -1, 0,   -1,   77,  0, int'(ERR_ZPROOF)},
    '{-1, 257,          2,            0,   -1, 0,   -1,   77,  0, int'(ERR_COUNT)},
    '{1,  1,            1,            1,   0,  2,   -1,   151, 0, int'(ERR_TYPE)},
    '{-1, 1,            4,            1,   0,  255, -1,   154, 0, int'(ERR_TYPE)},
    '{-1, 0,            1,            0,   -1, 0,   0,    0,   2, int'(ERR_TRAIL)},
    '{-1, 1,            1,            1,   -1, 0,   -1,   76,  0, int'(ERR_TRUNC)},
    '{-1, 0,            32'hFFFFFFFF, 0,   -1, 0,   -1,   100, 0, int'(ERR_TRUNC)},
    '{-1, 32'hFFFFFFFF, 0,            0,   -1, 0,   -1,   77,  0, int'(ERR_ZPROOF)},
    '{0,  1,            1,            1,   -1, 0,   -1,   77,  0, int'(ERR_COUNT)},
    '{65535, 65536,     1,            0,   -1, 0,   -1,   77,  0, int'(ERR_COUNT)},
    '{-1, 65535,        1,            0,   -1, 0,   -1,   80,  0, int'(ERR_TRUNC)}
  };

  function automatic logic [31:0] span_of(logic [3:0] st);
    case (st)
      FC_ID, FC_COUNT, FC_PSIZE:           return 32'd4;
      FC_PREV, FC_NEW, FC_COMMIT, FC_NULL: return 32'd32;
      FC_PROOF:                            return proof_len;
      FC_VALUE:                            return 32'd8;
      FC_TYPE:                             return 32'd1;
      FC_DEST:                             return 32'd20;
      default:                             return 32'(SIG_BYTES);
    endcase
  endfunction

  task automatic clear_parse();
    stage       = FC_ID;
    pos         = '0;
    entry_idx   = '0;
    entries_hdr = '0;
    proof_len   = '0;
    gather      = '0;
    first_err   = ERR_NONE;
  endtask

  task automatic tag_byte(input logic [7:0] b, input logic last, output tag_t r);
    r = '{b, FC_IGNORED, 32'd0, 16'd0, 1'b0, 1'b0, 3'd0};
    if (stage == FC_IGNORED) begin
      if (first_err == ERR_NONE) first_err = ERR_TRAIL;
    end else begin
      r.code   = stage;
      r.offset = pos;
      if (stage >= FC_COMMIT && stage <= FC_DEST) r.entry = entry_idx;
      if ((stage == FC_ID || stage == FC_COUNT || stage == FC_PSIZE) && pos < 4)
        gather = gather | (32'(b) << (8 * pos));
      if (stage == FC_TYPE && b > 8'd1) first_err = ERR_TYPE;
      pos = pos + 1;
      if (first_err != ERR_NONE) begin
        stage = FC_IGNORED;
        pos   = '0;
      end else if (pos >= span_of(stage)) begin
        pos = '0;
        case (stage)
          FC_ID:     begin gather = '0; stage = FC_PREV; end
          FC_PREV:   stage = FC_NEW;
          FC_NEW:    stage = FC_COUNT;
          FC_COUNT:  begin entries_hdr = gather; gather = '0; stage = FC_PSIZE; end
          FC_PSIZE: begin
            proof_len = gather;
            gather    = '0;
            if (proof_len == 0) begin
              first_err = ERR_ZPROOF;
              stage     = FC_IGNORED;
            end else if (entries_hdr > {16'd0, max_entries}) begin
              first_err = ERR_COUNT;
              stage     = FC_IGNORED;
            end else begin
              stage = FC_PROOF;
            end
          end
          FC_PROOF: begin
            entry_idx = '0;
            stage = (entries_hdr == 0) ? FC_SIG : FC_COMMIT;
          end
          FC_COMMIT: stage = FC_NULL;
          FC_NULL:   stage = FC_VALUE;
          FC_VALUE:  stage = FC_TYPE;
          FC_TYPE:   stage = FC_DEST;
          FC_DEST: begin
            entry_idx = entry_idx + 16'd1;
            stage = ({16'd0, entry_idx} >= entries_hdr) ? FC_SIG : FC_COMMIT;
          end
          default:   stage = FC_IGNORED;
        endcase
      end
    end
    if (last) begin
      r.done = 1'b1;
      if (stage != FC_IGNORED && first_err == ERR_NONE) first_err = ERR_TRUNC;
      r.err = first_err;
      r.ok  = (first_err == ERR_NONE);
      clear_parse();
    end
  endtask

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      fails++;
    end
  endfunction

  initial begin
    clear_parse();
    max_entries = MAX_COUNT_RST;
  end

  always @(posedge clk_i) begin
    tag_t w;
    tag_t got;
    int   st;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{m_axis_tdata[7:0], m_axis_tuser, m_axis_tdata[39:8], m_axis_tdata[55:40],
                m_axis_tlast, m_axis_tdata[56], m_axis_tdata[59:57]};
        if (want_tags.size() == 0) begin
          $display("%0t: unexpected beat, expected none, actual byte %0h code %0d",
                   $time, got.data, got.code);
          fails++;
        end else begin
          w = want_tags.pop_front();
          check_field("out_byte", 32'(w.data), 32'(got.data));
          check_field("field_code", 32'(w.code), 32'(got.code));
          check_field("field_offset", w.offset, got.offset);
          check_field("entry_number", 32'(w.entry), 32'(got.entry));
          check_field("frame_done", 32'(w.done), 32'(got.done));
          check_field("frame_ok", 32'(w.ok), 32'(got.ok));
          check_field("error_code", 32'(w.err), 32'(got.err));
        end
        if (got.done && want_status.size() != 0) begin
          st = want_status.pop_front();
          if (st >= 0) check_field("frame status", st, 32'(got.err));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        tag_byte(s_axis_tdata, s_axis_tlast, w);
        want_tags.insert(want_tags.size(), w);
      end
      if (cfg_we_i) max_entries = cfg_wdata_i;
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
  end

  function automatic int gap_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // sink side: random stalls, plus one long hold on request
  initial begin
    int wait_left;
    int hold_left;
    wait_left = 0;
    hold_left = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (wait_left > 0) begin
        wait_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (!rx_calm && $urandom_range(0, 3) == 0) wait_left = gap_len();
      end
    end
  end

  initial begin
    while (idle_cycles < WATCHDOG) @(posedge clk_i);
    $display("batch_proof_frame_parser_tb NOT OK");
    $finish;
  end

  function automatic logic [7:0] fill_byte(int fill);
    return (fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill);
  endfunction

  function automatic void append_byte(logic [7:0] v);
    frame_bytes.insert(frame_bytes.size(), v);
  endfunction

  function automatic logic [15:0] pick_max();
    case ($urandom_range(0, 5))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(0, 3));
      3:       return MAX_COUNT_RST;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = (tx_calm || $urandom_range(0, 2) != 0) ? 0 : gap_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    @(negedge clk_i);
    while (!s_axis_tready) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (want_tags.size() != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic write_max(input logic [15:0] v);
    wait_drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic build_frame(input frame_spec_t s);
    int n_proof;
    frame_bytes.delete();
    repeat (68) append_byte(fill_byte(s.fill));
    for (int k = 0; k < 4; k++) append_byte(s.count_val[8*k +: 8]);
    for (int k = 0; k < 4; k++) append_byte(s.proof_val[8*k +: 8]);
    n_proof = (s.proof_val > 1024) ? 1024 : int'(s.proof_val);
    repeat (n_proof) append_byte(fill_byte(s.fill));
    for (int e = 0; e < s.n_ent; e++) begin
      repeat (72) append_byte(fill_byte(s.fill));
      append_byte((e == s.bad_ent) ? 8'(s.bad_val) : 8'($urandom_range(0, 1)));
      repeat (20) append_byte(fill_byte(s.fill));
    end
    repeat (SIG_BYTES) append_byte(fill_byte(s.fill));
    if (s.trunc_len > 0)
      while (frame_bytes.size() > s.trunc_len) void'(frame_bytes.pop_back());
    repeat (s.extra) append_byte(fill_byte(-1));
  endtask

  task automatic send_frame(input int want_err);
    want_status.insert(want_status.size(), want_err);
    for (int i = 0; i < frame_bytes.size(); i++) begin
      if (want_err < 0) begin
        if ($urandom_range(0, 299) == 0) wait_drain();
        else if ($urandom_range(0, 399) == 0) write_max(pick_max());
      end
      send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
      sent_bytes++;
    end
  endtask

  task automatic random_frame();
    frame_spec_t s;
    int          r;
    int          full;
    r = $urandom_range(0, 99);
    s = '{-1, 32'($urandom_range(0, 3)), 32'($urandom_range(1, 8)), 0, -1, 0, -1, 0, 0, -1};
    if ($urandom_range(0, 9) == 0) s.proof_val = $urandom_range(1, 40);
    s.n_ent = int'(s.count_val);
    if (r < 45) begin
    end else if (r < 55) begin
      s.extra = $urandom_range(1, 5);
    end else if (r < 70) begin
      full = 76 + int'(s.proof_val) + 93 * s.n_ent + SIG_BYTES;
      s.trunc_len = $urandom_range(1, full - 1);
    end else if (r < 78) begin
      if (s.n_ent == 0) begin
        s.count_val = 1;
        s.n_ent     = 1;
      end
      s.bad_ent = $urandom_range(0, s.n_ent - 1);
      s.bad_val = $urandom_range(2, 255);
    end else if (r < 84) begin
      s.proof_val = 0;
    end else if (r < 90) begin
      s.count_val = $urandom_range(4, 70000);
      s.n_ent     = 0;
    end
    if (r < 90) begin
      build_frame(s);
    end else begin
      frame_bytes.delete();
      repeat ($urandom_range(1, 20)) append_byte(fill_byte(-1));
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      tx_calm = ($urandom_range(0, 2) == 0);
      rx_calm = ($urandom_range(0, 2) == 0);
      if (plan[i].cfg >= 0) write_max(16'(plan[i].cfg));
      build_frame(plan[i]);
      send_frame(plan[i].want_err);
    end

    sent_bytes = 0;
    hold_req   = 1'b1;
    tx_calm    = 1'b1;
    random_frame();
    send_frame(-1);
    while (sent_bytes < RAND_BYTES) begin
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 3) == 0) write_max(pick_max());
      random_frame();
      send_frame(-1);
    end

    wait_drain();
    repeat (8) @(posedge clk_i);
    if (want_tags.size() != 0) begin
      $display("%0t: pending beats, expected 0, actual %0d", $time, want_tags.size());
      fails++;
    end
    if (fails == 0)
      $display("batch_proof_frame_parser_tb OK");
    else
      $display("batch_proof_frame_parser_tb NOT OK");
    $finish;
  end

endmodule
